FILE: sv/frm_pkg.sv
`default_nettype none

package frm_pkg;

    // Bytes ahead of the payload in the byte count of a frame: start, ID and length.
    localparam int HEADER_BYTES = 3;

    // At most this many results come out for one raw byte pushed in.
    localparam int RESULT_LIMIT = 64;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_VALUE  = 3'd0;
    localparam logic [2:0] REG_END_VALUE    = 3'd1;
    localparam logic [2:0] REG_ESCAPE_VALUE = 3'd2;
    localparam logic [2:0] REG_ESCAPE_XOR   = 3'd3;
    localparam logic [2:0] REG_IDS_LOW      = 3'd4;
    localparam logic [2:0] REG_IDS_MID      = 3'd5;
    localparam logic [2:0] REG_IDS_UPPER    = 3'd6;
    localparam logic [2:0] REG_IDS_TOP      = 3'd7;

    // Live configuration as seen by the parser.
    typedef struct packed {
        logic [7:0]   start_value;
        logic [7:0]   end_value;
        logic [7:0]   escape_value;
        logic [7:0]   escape_xor;
        logic [255:0] ids_valid;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [7:0] frame_id;
        logic [7:0] payload_byte;
        logic [4:0] byte_position;
        logic       no_payload;
        logic       last_of_packet;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/frm_ram.sv
`default_nettype none

module frm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/frm_fifo.sv
`default_nettype none

module frm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_data  = r_mem[r_rp[AW-1:0]];

    // Pointers carry one extra wrap bit to tell full from empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + (AW+1)'(1);
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + (AW+1)'(1);
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/frm_parser.sv
`default_nettype none

module frm_parser
    import frm_pkg::*;
#(
    parameter int PAYLOAD_MAX   = 32,
    parameter int FRAME_MAX     = 37,
    parameter int HISTORY_DEPTH = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_in_byte,
    output logic            o_in_pop,
    output t_result         o_res,
    output logic            o_res_push,
    input  wire logic       i_res_full
);

    localparam int PW  = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int FW  = $clog2(FRAME_MAX + 1);
    localparam int HPW = $clog2(HISTORY_DEPTH + 1);
    localparam int RW  = $clog2(HISTORY_DEPTH + 2);

    // Frame phases.
    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_CHK  = 3'd4;
    localparam logic [2:0] PH_END  = 3'd5;

    // Sequencer states.
    localparam logic [1:0] ST_FETCH   = 2'd0;
    localparam logic [1:0] ST_PARSE   = 2'd1;
    localparam logic [1:0] ST_EMIT_RD = 2'd2;
    localparam logic [1:0] ST_EMIT_WR = 2'd3;

    function automatic logic id_ok(input logic [255:0] bitmap, input logic [7:0] id);
        return bitmap[id];
    endfunction

    logic [1:0]     r_state, n_state;
    logic [2:0]     r_phase, n_phase;
    logic           r_esc, n_esc;
    logic [FW-1:0]  r_fc, n_fc;
    logic [7:0]     r_dl, n_dl;
    logic [7:0]     r_sum, n_sum;
    logic [7:0]     r_held, n_held;
    logic [HPW-1:0] r_hp, n_hp;
    logic [RW-1:0]  r_rd, n_rd;
    logic [RW-1:0]  r_wr, n_wr;
    logic [RW-1:0]  r_p0, n_p0;
    logic [6:0]     r_rc, n_rc;
    logic [7:0]     r_ei, n_ei;

    logic           ring_we;
    logic           ring_re;
    logic [7:0]     ring_rdata;
    logic           store_we;
    logic [PW-1:0]  store_waddr;
    logic [7:0]     store_wdata;
    logic           store_re;
    logic [7:0]     store_rdata;

    logic [2:0]     ph;
    logic           do_parse;
    logic           bad;
    logic           good;
    logic [7:0]     dval;
    logic [9:0]     pay_idx;
    logic           ei_last;
    logic           limit_hit;

    // History ring: every raw byte goes here once; a rescan rewinds the read pointer.
    frm_ram #(
        .WIDTH (8),
        .DEPTH (2**RW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wr),
        .i_wdata (i_in_byte),
        .i_re    (ring_re),
        .i_raddr (r_rd),
        .o_rdata (ring_rdata)
    );

    // Payload store of the frame under way.
    frm_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (r_ei[PW-1:0]),
        .o_rdata (store_rdata)
    );

    assign pay_idx     = 10'(r_fc) - 10'(HEADER_BYTES);
    assign store_waddr = pay_idx[PW-1:0];
    assign store_wdata = dval;
    assign ei_last     = (9'(r_ei) + 9'd1) == 9'(r_dl);
    assign limit_hit   = (r_rc >= 7'(RESULT_LIMIT));

    // Sequencer and frame parser.
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_fc     = r_fc;
        n_dl     = r_dl;
        n_sum    = r_sum;
        n_held   = r_held;
        n_hp     = r_hp;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_p0     = r_p0;
        n_rc     = r_rc;
        n_ei     = r_ei;
        o_in_pop = 1'b0;
        ring_we  = 1'b0;
        ring_re  = 1'b0;
        store_we = 1'b0;
        store_re = 1'b0;
        o_res_push = 1'b0;
        o_res    = '0;
        ph       = r_phase;
        do_parse = 1'b0;
        bad      = 1'b0;
        good     = 1'b0;
        dval     = ring_rdata;

        unique case (r_state)
            ST_FETCH: begin
                if (r_rd != r_wr) begin
                    ring_re = 1'b1;
                    n_state = ST_PARSE;
                end else if (i_in_valid) begin
                    // A new raw byte opens a new result budget.
                    o_in_pop = 1'b1;
                    ring_we  = 1'b1;
                    n_wr     = r_wr + RW'(1);
                    n_rc     = '0;
                end
            end

            ST_PARSE: begin
                n_rd = r_rd + RW'(1);

                // Record the raw byte while in a frame, or drop a frame whose history is full.
                if (r_phase != PH_WAIT) begin
                    if (r_hp == HPW'(HISTORY_DEPTH)) begin
                        ph   = PH_WAIT;
                        n_hp = '0;
                    end else begin
                        n_hp = r_hp + HPW'(1);
                    end
                end

                // Escape layer.
                if (r_esc) begin
                    n_esc    = 1'b0;
                    do_parse = 1'b1;
                    dval     = ring_rdata ^ i_cfg.escape_xor;
                end else if (ring_rdata == i_cfg.escape_value) begin
                    n_esc = 1'b1;
                end else begin
                    do_parse = 1'b1;
                end

                n_phase = ph;
                if (do_parse) begin
                    case (ph)
                        PH_WAIT: begin
                            if (dval == i_cfg.start_value) begin
                                n_fc    = FW'(1);
                                n_sum   = '0;
                                n_p0    = r_rd;
                                n_hp    = HPW'(1);
                                n_phase = PH_ID;
                            end
                        end
                        PH_ID: begin
                            n_fc = r_fc + FW'(1);
                            if (!id_ok(i_cfg.ids_valid, dval)) begin
                                bad = 1'b1;
                            end else begin
                                n_held  = dval;
                                n_sum   = dval;
                                n_phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            n_fc  = r_fc + FW'(1);
                            n_sum = r_sum + dval;
                            n_dl  = dval;
                            if (9'(dval) > 9'(PAYLOAD_MAX)) begin
                                bad = 1'b1;
                            end else if (dval == 8'd0) begin
                                n_phase = PH_CHK;
                            end else begin
                                n_phase = PH_PAY;
                            end
                        end
                        PH_PAY: begin
                            store_we = 1'b1;
                            n_fc     = r_fc + FW'(1);
                            n_sum    = r_sum + dval;
                            if ((10'(r_fc) + 10'd1) >= (10'(r_dl) + 10'(HEADER_BYTES))) begin
                                n_phase = PH_CHK;
                            end
                        end
                        PH_CHK: begin
                            n_fc = r_fc + FW'(1);
                            if (r_sum == dval) begin
                                n_phase = PH_END;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        default: begin
                            n_fc = r_fc + FW'(1);
                            if (dval == i_cfg.end_value && id_ok(i_cfg.ids_valid, r_held)) begin
                                good    = 1'b1;
                                n_phase = PH_WAIT;
                                n_hp    = '0;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                    endcase
                end

                // A bad frame rescans from the raw byte after its start byte.
                if (bad) begin
                    n_phase = PH_WAIT;
                    n_rd    = r_p0 + RW'(1);
                    n_hp    = '0;
                    n_esc   = 1'b0;
                end else if (n_phase != PH_WAIT && 10'(n_fc) >= 10'(FRAME_MAX)) begin
                    n_phase = PH_WAIT;
                    n_hp    = '0;
                end

                if (good) begin
                    n_ei    = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_FETCH;
                end
            end

            ST_EMIT_RD: begin
                if (r_dl == 8'd0) begin
                    o_res.frame_id       = r_held;
                    o_res.no_payload     = 1'b1;
                    o_res.last_of_packet = 1'b1;
                    if (limit_hit) begin
                        n_state = ST_FETCH;
                    end else if (!i_res_full) begin
                        o_res_push = 1'b1;
                        n_rc       = r_rc + 7'd1;
                        n_state    = ST_FETCH;
                    end
                end else begin
                    store_re = 1'b1;
                    n_state  = ST_EMIT_WR;
                end
            end

            ST_EMIT_WR: begin
                o_res.frame_id       = r_held;
                o_res.payload_byte   = store_rdata;
                o_res.byte_position  = r_ei[4:0];
                o_res.no_payload     = 1'b0;
                o_res.last_of_packet = ei_last;
                if (limit_hit || !i_res_full) begin
                    if (!limit_hit) begin
                        o_res_push = 1'b1;
                        n_rc       = r_rc + 7'd1;
                    end
                    n_ei    = r_ei + 8'd1;
                    n_state = ei_last ? ST_FETCH : ST_EMIT_RD;
                end
            end

            default: begin
                n_state = ST_FETCH;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FETCH;
            r_phase <= PH_WAIT;
            r_esc   <= 1'b0;
            r_fc    <= '0;
            r_dl    <= '0;
            r_sum   <= '0;
            r_held  <= '0;
            r_hp    <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_p0    <= '0;
            r_rc    <= '0;
            r_ei    <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_fc    <= n_fc;
            r_dl    <= n_dl;
            r_sum   <= n_sum;
            r_held  <= n_held;
            r_hp    <= n_hp;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_p0    <= n_p0;
            r_rc    <= n_rc;
            r_ei    <= n_ei;
        end
    end

    // Outside a frame no history is counted.
    a_hp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_hp == '0))
        else $error("history count nonzero while waiting for start");

    // The history count never passes the history depth.
    a_hp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hp <= HPW'(HISTORY_DEPTH))
        else $error("history count over depth");

    // Results go out only into free room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    // New raw bytes enter the ring only once every earlier byte has been parsed.
    a_ring_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |-> (r_rd == r_wr && r_state == ST_FETCH))
        else $error("ring appended while replay pending");

endmodule

`default_nettype wire

FILE: sv/framed_packet_receiver_top.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         push / full            i_raw_byte
// result    out        empty / pop            o_frame_id, o_payload_byte, o_byte_position,
//                                              o_no_payload, o_last_of_packet
// config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_wdata
//
// A raw byte is first written into the history ring, then read back from the ring and parsed
// (ring read, then parse); no new raw byte is taken until every earlier one is parsed.
// A rescan replays up to HISTORY_DEPTH recorded bytes from the ring.
// A good packet then reads the payload store for each payload result before pushing it.
// Reset clears all control state; the ring and payload store are not cleared.
// A full result queue stalls only the parser; the input queue keeps taking bytes until full.

module framed_packet_receiver_top
    import frm_pkg::*;
#(
    parameter int PAYLOAD_MAX   = 32,
    parameter int FRAME_MAX     = 37,
    parameter int HISTORY_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_raw_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic      [7:0]  o_frame_id,
    output logic      [7:0]  o_payload_byte,
    output logic      [4:0]  o_byte_position,
    output logic             o_no_payload,
    output logic             o_last_of_packet,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_wdata
);

    t_cfg         r_cfg;
    logic         in_empty;
    logic [7:0]   in_byte;
    logic         in_pop;
    t_result      res;
    logic         res_push;
    logic         res_full;
    logic [$bits(t_result)-1:0] res_head;
    t_result      head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_value  <= 8'd126;
            r_cfg.end_value    <= 8'd127;
            r_cfg.escape_value <= 8'd125;
            r_cfg.escape_xor   <= 8'd32;
            r_cfg.ids_valid    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_VALUE:  r_cfg.start_value       <= i_cfg_wdata[7:0];
                REG_END_VALUE:    r_cfg.end_value         <= i_cfg_wdata[7:0];
                REG_ESCAPE_VALUE: r_cfg.escape_value      <= i_cfg_wdata[7:0];
                REG_ESCAPE_XOR:   r_cfg.escape_xor        <= i_cfg_wdata[7:0];
                REG_IDS_LOW:      r_cfg.ids_valid[63:0]   <= i_cfg_wdata;
                REG_IDS_MID:      r_cfg.ids_valid[127:64] <= i_cfg_wdata;
                REG_IDS_UPPER:    r_cfg.ids_valid[191:128] <= i_cfg_wdata;
                REG_IDS_TOP:      r_cfg.ids_valid[255:192] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: input queue of raw bytes.
    frm_fifo #(
        .WIDTH (8),
        .DEPTH (4)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_raw_byte),
        .o_full  (full),
        .i_pop   (in_pop),
        .o_data  (in_byte),
        .o_empty (in_empty)
    );

    // Back: unescaping, frame parsing, rescans and payload runs.
    frm_parser #(
        .PAYLOAD_MAX   (PAYLOAD_MAX),
        .FRAME_MAX     (FRAME_MAX),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (!in_empty),
        .i_in_byte  (in_byte),
        .o_in_pop   (in_pop),
        .o_res      (res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    // Result queue toward the consumer.
    frm_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (4)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign head             = t_result'(res_head);
    assign o_frame_id       = head.frame_id;
    assign o_payload_byte   = head.payload_byte;
    assign o_byte_position  = head.byte_position;
    assign o_no_payload     = head.no_payload;
    assign o_last_of_packet = head.last_of_packet;

endmodule

`default_nettype wire
